### sv/assert_macros.svh
// assertion macros for the rtl files of the tracker
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/fust_pkg.sv
// package for the first unique symbol tracker: widths, defaults and link types
// no dependencies; imported by fust_cell and the top level
`timescale 1ns / 1ps

package fust_pkg;

    localparam int unsigned SYM_W             = 5;
    localparam int unsigned ALPHABET_SIZE_DEF = 26;

    // update chain, moves left to right over the pre-update state
    typedef struct packed {
        logic prev_valid;
        logic hit;
    } t_link;

    // priority pick chain over the registered state
    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] sym;
    } t_pick;

endpackage

### sv/fust_cell.sv
// one slot of the arrival order: symbol, valid and repeat flag
// depends on fust_pkg; instanced in a row by first_unique_symbol_tracker_unit
`timescale 1ns / 1ps

module fust_cell
    import fust_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_start,
    input  logic             i_letter_ok,
    input  logic [SYM_W-1:0] i_letter,
    input  t_link            i_link,
    output t_link            o_link,
    input  t_pick            i_pick,
    output t_pick            o_pick,
    output logic             o_valid
);

    logic             r_valid;
    logic             r_many;
    logic [SYM_W-1:0] r_sym;
    logic             n_valid;
    logic             n_many;
    logic [SYM_W-1:0] n_sym;
    logic             w_eff_valid;
    logic             w_match;
    logic             w_claim;

    always_comb begin
        w_eff_valid = r_valid & ~i_start;
        w_match     = w_eff_valid & (r_sym == i_letter);
        w_claim     = i_letter_ok & i_link.prev_valid & ~w_eff_valid & ~i_link.hit;

        o_link.prev_valid = w_eff_valid;
        o_link.hit        = i_link.hit | w_match;

        n_valid = w_eff_valid | w_claim;
        n_sym   = w_claim ? i_letter : r_sym;
        n_many  = w_match ? 1'b1 : (w_claim ? 1'b0 : r_many);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sym  <= n_sym;
            r_many <= n_many;
        end
    end

    // earliest slot seen exactly once wins
    always_comb begin
        if (i_pick.found) begin
            o_pick = i_pick;
        end else if (r_valid && !r_many) begin
            o_pick.found = 1'b1;
            o_pick.sym   = r_sym;
        end else begin
            o_pick = i_pick;
        end
    end

    assign o_valid = r_valid;

endmodule

### sv/first_unique_symbol_tracker_unit.sv
// top level of the first unique symbol tracker: row of fust_cell slots and result register
// depends on fust_pkg, fust_cell and assert_macros.svh
//
//  channel | dir | tdata             | tuser
//  s_axis  | in  | [4:0] letter      | [0] start_of_string
//  m_axis  | out | [4:0] first_unique| [0] found
//
// one item per cycle sustained while the result is not stalled: an item updates the cell
// row when it is accepted, and the pick over the row is registered into the result when it can load
// the update and pick chains ripple through ALPHABET_SIZE cells and set the clock
// reset clears the valid bits of all cells and both control flags at once
// a stalled result holds; the next item is still taken if the result register frees
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_unique_symbol_tracker_unit
    import fust_pkg::*;
#(
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic [0:0] s_axis_tuser,   // [0] start_of_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [4:0] first_unique, [7:5] zero
    output logic [0:0] m_axis_tuser    // [0] found
);

    localparam int unsigned CMP_W = $clog2(ALPHABET_SIZE + 1);
    localparam int unsigned LIM_W = (CMP_W > SYM_W) ? CMP_W : SYM_W;

    logic                     r_pend;
    logic                     r_ovalid;
    logic                     r_found;
    logic [SYM_W-1:0]         r_sym;
    logic                     w_accept;
    logic                     w_can_load;
    logic                     w_load;
    logic                     w_letter_ok;
    logic [SYM_W-1:0]         w_letter;
    logic [ALPHABET_SIZE-1:0] w_valid;
    t_link                    w_link [ALPHABET_SIZE+1];
    t_pick                    w_pick [ALPHABET_SIZE+1];

    assign w_letter    = s_axis_tdata[SYM_W-1:0];
    assign w_letter_ok = LIM_W'(w_letter) < LIM_W'(ALPHABET_SIZE);

    assign w_can_load    = !r_ovalid || m_axis_tready;
    assign w_load        = r_pend && w_can_load;
    assign s_axis_tready = !r_pend || w_can_load;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_link[0].prev_valid = 1'b1;
    assign w_link[0].hit        = 1'b0;
    assign w_pick[0].found      = 1'b0;
    assign w_pick[0].sym        = '0;

    for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
        fust_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_accept),
            .i_start    (s_axis_tuser[0]),
            .i_letter_ok(w_letter_ok),
            .i_letter   (w_letter),
            .i_link     (w_link[k]),
            .o_link     (w_link[k+1]),
            .i_pick     (w_pick[k]),
            .o_pick     (w_pick[k+1]),
            .o_valid    (w_valid[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_found <= w_pick[ALPHABET_SIZE].found;
            r_sym   <= w_pick[ALPHABET_SIZE].sym;
        end
    end

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = {{(8 - SYM_W){1'b0}}, r_sym};
    assign m_axis_tuser[0] = r_found;

    // occupied slots always form a prefix of the row
    `ASSERT_NEVER(a_valid_prefix, i_clk, i_rst_n,
        ((w_valid + ALPHABET_SIZE'(1)) & w_valid) != '0, "cell valid bits not a prefix")
    // a pending pick that cannot load stays pending
    `ASSERT_CLK(a_pend_kept, i_clk, i_rst_n, (r_pend && !w_can_load) |=> r_pend,
        "pending result dropped")
    // a start item leaves at most the first slot occupied
    `ASSERT_CLK(a_start_clear, i_clk, i_rst_n,
        (w_accept && s_axis_tuser[0])
            |=> ($countones(w_valid) <= 1 && (w_valid[0] || w_valid == '0)),
        "start did not clear the row")

endmodule
